// ===== sv/i2cbm_pkg.sv =====
// Shared types and constants for the I2C bit-level master.
package i2cbm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_STA_A = 4'd1,
    PH_STA_B = 4'd2,
    PH_STO_A = 4'd3,
    PH_STO_B = 4'd4,
    PH_WR_LO = 4'd5,
    PH_WR_HI = 4'd6,
    PH_AK_LO = 4'd7,
    PH_AK_HI = 4'd8,
    PH_RD_LO = 4'd9,
    PH_RD_HI = 4'd10,
    PH_MA_LO = 4'd11,
    PH_MA_HI = 4'd12
  } phase_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_POLL    = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd8;
  localparam logic [7:0]  ACK_POLL_RESET    = 8'd250;
  localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  // Packed so that scl_level sits in bit 0 of the beat.
  typedef struct packed {
    logic [1:0] pad;
    logic       nack_seen;
    logic [7:0] received_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

// ===== sv/i2cbm_seq.sv =====
// Bus sequencer: one tick per accepted beat, state update and result per tick.
module i2cbm_seq (
  input  logic              clk,
  input  logic              rst,
  input  i2cbm_pkg::cfg_t   cfg,
  input  logic              tick,
  input  logic              command_valid,
  input  logic [1:0]        operation,
  input  logic [7:0]        send_data,
  input  logic              reply_nack,
  input  logic              sda_sample,
  output i2cbm_pkg::result_t result
);
  import i2cbm_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] half_timer, half_timer_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        nack_reg, nack_reg_next;
  logic [7:0]  recv_reg, recv_reg_next;
  logic        ack_choice, ack_choice_next;
  logic        done;
  logic        released;

  logic [15:0] hp;
  logic [7:0]  lim;
  logic [15:0] timer_inc;
  logic        expired;
  logic [7:0]  shift_left;
  logic [3:0]  bit_inc;
  logic [7:0]  poll_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_count  <= '0;
      shift_reg  <= '0;
      half_timer <= '0;
      poll_count <= '0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      nack_reg   <= 1'b0;
      recv_reg   <= '0;
      ack_choice <= 1'b0;
    end else if (tick) begin
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      half_timer <= half_timer_next;
      poll_count <= poll_count_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      nack_reg   <= nack_reg_next;
      recv_reg   <= recv_reg_next;
      ack_choice <= ack_choice_next;
    end
  end

  assign hp         = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
  assign lim        = (cfg.ack_poll_limit == '0) ? 8'd1 : cfg.ack_poll_limit;
  assign timer_inc  = half_timer + 16'd1;
  assign expired    = timer_inc >= hp;
  assign shift_left = {shift_reg[6:0], 1'b0};
  assign bit_inc    = bit_count + 4'd1;
  assign poll_inc   = poll_count + 8'd1;

  always_comb begin
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    half_timer_next = half_timer;
    poll_count_next = poll_count;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    nack_reg_next   = nack_reg;
    recv_reg_next   = recv_reg;
    ack_choice_next = ack_choice;
    done            = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (command_valid) begin
          bit_count_next  = '0;
          half_timer_next = '0;
          case (op_t'(operation))
            OP_START: begin
              phase_next   = PH_STA_A;
              scl_reg_next = 1'b1;
              sda_reg_next = 1'b1;
            end
            OP_STOP: begin
              phase_next   = PH_STO_A;
              scl_reg_next = 1'b0;
              sda_reg_next = 1'b0;
            end
            OP_WRITE: begin
              shift_reg_next = send_data;
              phase_next     = PH_WR_LO;
              scl_reg_next   = 1'b0;
              sda_reg_next   = send_data[7];
            end
            default: begin
              shift_reg_next  = '0;
              ack_choice_next = reply_nack;
              phase_next      = PH_RD_LO;
              scl_reg_next    = 1'b0;
              sda_reg_next    = 1'b1;
            end
          endcase
        end
      end
      PH_AK_HI: begin
        if (!sda_sample) begin
          nack_reg_next   = 1'b0;
          phase_next      = PH_IDLE;
          half_timer_next = '0;
          scl_reg_next    = 1'b0;
          sda_reg_next    = 1'b1;
          done            = 1'b1;
        end else begin
          poll_count_next = poll_inc;
          if (poll_inc >= lim) begin
            nack_reg_next   = 1'b1;
            phase_next      = PH_STO_A;
            half_timer_next = '0;
            scl_reg_next    = 1'b0;
            sda_reg_next    = 1'b0;
          end
        end
      end
      PH_STA_A, PH_STA_B, PH_STO_A, PH_STO_B, PH_WR_LO, PH_WR_HI, PH_AK_LO,
      PH_RD_LO, PH_RD_HI, PH_MA_LO, PH_MA_HI: begin
        half_timer_next = timer_inc;
        if (expired) begin
          half_timer_next = '0;
          case (phase)
            PH_STA_A: begin
              phase_next   = PH_STA_B;
              scl_reg_next = 1'b1;
              sda_reg_next = 1'b0;
            end
            PH_STA_B: begin
              phase_next   = PH_IDLE;
              scl_reg_next = 1'b0;
              sda_reg_next = 1'b0;
              done         = 1'b1;
            end
            PH_STO_A: begin
              phase_next   = PH_STO_B;
              scl_reg_next = 1'b1;
              sda_reg_next = 1'b0;
            end
            PH_STO_B: begin
              phase_next   = PH_IDLE;
              scl_reg_next = 1'b1;
              sda_reg_next = 1'b1;
              done         = 1'b1;
            end
            PH_WR_LO: begin
              phase_next   = PH_WR_HI;
              scl_reg_next = 1'b1;
            end
            PH_WR_HI: begin
              shift_reg_next = shift_left;
              bit_count_next = bit_inc;
              scl_reg_next   = 1'b0;
              if (bit_inc >= BITS_PER_BYTE) begin
                phase_next   = PH_AK_LO;
                sda_reg_next = 1'b1;
              end else begin
                phase_next   = PH_WR_LO;
                sda_reg_next = shift_left[7];
              end
            end
            PH_AK_LO: begin
              poll_count_next = '0;
              phase_next      = PH_AK_HI;
              scl_reg_next    = 1'b1;
              sda_reg_next    = 1'b1;
            end
            PH_RD_LO: begin
              phase_next   = PH_RD_HI;
              scl_reg_next = 1'b1;
              sda_reg_next = 1'b1;
            end
            PH_RD_HI: begin
              shift_reg_next = {shift_reg[6:0], sda_sample};
              bit_count_next = bit_inc;
              scl_reg_next   = 1'b0;
              if (bit_inc >= BITS_PER_BYTE) begin
                phase_next   = PH_MA_LO;
                sda_reg_next = ack_choice;
              end else begin
                phase_next   = PH_RD_LO;
                sda_reg_next = 1'b1;
              end
            end
            PH_MA_LO: begin
              phase_next   = PH_MA_HI;
              scl_reg_next = 1'b1;
              sda_reg_next = ack_choice;
            end
            default: begin
              recv_reg_next = shift_reg;
              phase_next    = PH_IDLE;
              scl_reg_next  = 1'b0;
              sda_reg_next  = ack_choice;
              done          = 1'b1;
            end
          endcase
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign released = (phase_next == PH_AK_LO) || (phase_next == PH_AK_HI) ||
                    (phase_next == PH_RD_LO) || (phase_next == PH_RD_HI);

  always_comb begin
    result               = '0;
    result.scl_level     = scl_reg_next;
    result.sda_level     = released ? 1'b1 : sda_reg_next;
    result.sda_drive     = !released;
    result.busy_res      = (phase_next != PH_IDLE);
    result.done_res      = done;
    result.received_data = recv_reg_next;
    result.nack_seen     = nack_reg_next;
  end

endmodule

// ===== sv/i2cbm_outbuf.sv =====
// Result register with a skid stage for the output stream.
module i2cbm_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  i2cbm_pkg::result_t push_data,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output i2cbm_pkg::result_t out_data
);
  import i2cbm_pkg::*;

  result_t skid_data;
  logic    skid_valid;

  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// ===== sv/i2c_bit_level_master_unit.sv =====
// Top level of the I2C bit-level master: config registers, sequencer, output buffer.
// Each input beat is one bus tick and yields exactly one result beat; a beat is
// taken every cycle, processed in a single registered pass through the phase
// sequencer, and held in a result register with a one-entry skid stage, so
// s_tready drops only when both are full. SCL timing is counted in beats:
// each timed half period lasts half_period_ticks beats (0 acts as 1), and an
// ACK poll consumes one beat per SDA sample, up to ack_poll_limit polls.
module i2c_bit_level_master_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // send_data[7:0], reply_nack[8], sda_sample[9], zero
  input  logic [2:0]  s_tuser,   // command_valid[0], operation[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level, sda_level, sda_drive, busy_res, done_res,
                                 // received_data[12:5], nack_seen[13], zero
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import i2cbm_pkg::*;

  cfg_t    cfg;
  logic    tick;
  result_t result;
  result_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_PERIOD_RESET;
      cfg.ack_poll_limit    <= ACK_POLL_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HALF_PERIOD: cfg.half_period_ticks <= cfg_wdata;
        CFG_ACK_POLL:    cfg.ack_poll_limit    <= cfg_wdata[7:0];
        default:         cfg.ack_poll_limit    <= cfg.ack_poll_limit;
      endcase
    end
  end

  assign tick = s_tvalid && s_tready;

  i2cbm_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .tick          (tick),
    .command_valid (s_tuser[0]),
    .operation     (s_tuser[2:1]),
    .send_data     (s_tdata[7:0]),
    .reply_nack    (s_tdata[8]),
    .sda_sample    (s_tdata[9]),
    .result        (result)
  );

  i2cbm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (result),
    .space     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data;

endmodule

// ===== sv/i2cbm_checker.sv =====
// Port-level checker for the I2C bit-level master, bound to the top level.
module i2cbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled while result register empty");

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted beat produced no pending result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> !m_tdata[3])
    else $error("done reported while still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind i2c_bit_level_master_unit i2cbm_checker u_i2cbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/tb_i2c_bit_level_master_unit.sv =====
// Self-checking testbench for the I2C bit-level master: tick stream in, checked level stream out.
module tb_i2c_bit_level_master_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbm_pkg::*;

  typedef struct packed {
    logic       cmd_valid;
    op_t        op;
    logic [7:0] send_data;
    logic       reply_nack;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    cfg_t       cfg;
    phase_t     ph;
    logic [3:0] bits;
    logic [7:0] shifter;
    logic [15:0] timer;
    logic [7:0] polls;
    logic       scl;
    logic       sda;
    logic       nack;
    logic [7:0] rx;
    logic       ack_sel;
  } bus_state_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  tick_t       tick_q[$];
  result_t     level_q[$];
  tick_t       bus_tick;
  bus_state_t  plan_st;
  bus_state_t  line_st;

  int unsigned cyc = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int          errors = 0;
  int          ticks_taken = 0;
  int          queued = 0;
  int          cmd_count[4] = '{0, 0, 0, 0};
  int          ack_timeouts = 0;
  int          settings = 0;

  wire calm = (cyc >= 1200) && (cyc < 1600);

  i2c_bit_level_master_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void goto_phase(inout bus_state_t st, input phase_t p,
                                     input logic scl, input logic sda);
    st.ph    = p;
    st.timer = '0;
    st.scl   = scl;
    st.sda   = sda;
  endfunction

  function automatic result_t step_bus(inout bus_state_t st, input tick_t t);
    result_t     r;
    logic [15:0] hp;
    logic [7:0]  lim;
    logic        done;
    logic        open_sda;
    hp   = (st.cfg.half_period_ticks == 16'd0) ? 16'd1 : st.cfg.half_period_ticks;
    lim  = (st.cfg.ack_poll_limit == 8'd0) ? 8'd1 : st.cfg.ack_poll_limit;
    done = 1'b0;
    if (st.ph == PH_IDLE) begin
      if (t.cmd_valid) begin
        st.bits = '0;
        case (t.op)
          OP_START: goto_phase(st, PH_STA_A, 1'b1, 1'b1);
          OP_STOP:  goto_phase(st, PH_STO_A, 1'b0, 1'b0);
          OP_WRITE: begin
            st.shifter = t.send_data;
            goto_phase(st, PH_WR_LO, 1'b0, t.send_data[7]);
          end
          default: begin
            st.shifter = '0;
            st.ack_sel = t.reply_nack;
            goto_phase(st, PH_RD_LO, 1'b0, 1'b1);
          end
        endcase
      end
    end else if (st.ph == PH_AK_HI) begin
      if (!t.sda_sample) begin
        st.nack = 1'b0;
        goto_phase(st, PH_IDLE, 1'b0, 1'b1);
        done = 1'b1;
      end else begin
        st.polls = st.polls + 8'd1;
        if (st.polls >= lim) begin
          st.nack = 1'b1;
          goto_phase(st, PH_STO_A, 1'b0, 1'b0);
        end
      end
    end else begin
      st.timer = st.timer + 16'd1;
      if (st.timer >= hp) begin
        case (st.ph)
          PH_STA_A: goto_phase(st, PH_STA_B, 1'b1, 1'b0);
          PH_STA_B: begin
            goto_phase(st, PH_IDLE, 1'b0, 1'b0);
            done = 1'b1;
          end
          PH_STO_A: goto_phase(st, PH_STO_B, 1'b1, 1'b0);
          PH_STO_B: begin
            goto_phase(st, PH_IDLE, 1'b1, 1'b1);
            done = 1'b1;
          end
          PH_WR_LO: goto_phase(st, PH_WR_HI, 1'b1, st.sda);
          PH_WR_HI: begin
            st.shifter = st.shifter << 1;
            st.bits    = st.bits + 4'd1;
            if (st.bits >= BITS_PER_BYTE) goto_phase(st, PH_AK_LO, 1'b0, 1'b1);
            else goto_phase(st, PH_WR_LO, 1'b0, st.shifter[7]);
          end
          PH_AK_LO: begin
            st.polls = '0;
            goto_phase(st, PH_AK_HI, 1'b1, 1'b1);
          end
          PH_RD_LO: goto_phase(st, PH_RD_HI, 1'b1, 1'b1);
          PH_RD_HI: begin
            st.shifter = {st.shifter[6:0], t.sda_sample};
            st.bits    = st.bits + 4'd1;
            if (st.bits >= BITS_PER_BYTE) goto_phase(st, PH_MA_LO, 1'b0, st.ack_sel);
            else goto_phase(st, PH_RD_LO, 1'b0, 1'b1);
          end
          PH_MA_LO: goto_phase(st, PH_MA_HI, 1'b1, st.ack_sel);
          PH_MA_HI: begin
            st.rx = st.shifter;
            goto_phase(st, PH_IDLE, 1'b0, st.ack_sel);
            done = 1'b1;
          end
          default: st.ph = PH_IDLE;
        endcase
      end
    end
    open_sda = (st.ph == PH_AK_LO) || (st.ph == PH_AK_HI) ||
               (st.ph == PH_RD_LO) || (st.ph == PH_RD_HI);
    r               = '0;
    r.scl_level     = st.scl;
    r.sda_level     = open_sda ? 1'b1 : st.sda;
    r.sda_drive     = !open_sda;
    r.busy_res      = (st.ph != PH_IDLE);
    r.done_res      = done;
    r.received_data = st.rx;
    r.nack_seen     = st.nack;
    return r;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.cmd_valid  = 1'($urandom_range(1));
    t.op         = op_t'($urandom_range(3));
    t.send_data  = 8'($urandom_range(255));
    t.reply_nack = 1'($urandom_range(1));
    t.sda_sample = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic queue_tick(input tick_t t);
    tick_q.push_back(t);
    void'(step_bus(plan_st, t));
    queued++;
  endtask

  task automatic idle_ticks(input int n);
    tick_t t;
    for (int i = 0; i < n; i++) begin
      t = random_tick();
      t.cmd_valid = 1'b0;
      queue_tick(t);
    end
  endtask

  // ack_after: NACK polls before the slave pulls SDA low; rx_byte: what the slave returns
  task automatic run_command(input op_t op, input logic [7:0] data, input logic rn,
                             input logic [7:0] rx_byte, input int ack_after,
                             input int noise_pct);
    tick_t t;
    t = random_tick();
    t.cmd_valid  = 1'b1;
    t.op         = op;
    t.send_data  = data;
    t.reply_nack = rn;
    queue_tick(t);
    while (plan_st.ph != PH_IDLE) begin
      t = random_tick();
      t.cmd_valid = ($urandom_range(99) < noise_pct);
      if (plan_st.ph == PH_AK_HI) t.sda_sample = (plan_st.polls < ack_after);
      else if (plan_st.ph == PH_RD_HI) t.sda_sample = rx_byte[7 - plan_st.bits];
      queue_tick(t);
    end
  endtask

  task automatic drain();
    while (tick_q.size() != 0 || s_tvalid) @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic addr, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_HALF_PERIOD) begin
      plan_st.cfg.half_period_ticks = val;
      line_st.cfg.half_period_ticks = val;
    end else begin
      plan_st.cfg.ack_poll_limit = val[7:0];
      line_st.cfg.ack_poll_limit = val[7:0];
    end
  endtask

  task automatic set_bus(input logic [15:0] hp, input logic [7:0] lim);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    write_cfg(CFG_HALF_PERIOD, hp);
    write_cfg(CFG_ACK_POLL, {junk, lim});
    settings++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // sender: hold the beat until taken, then predict its levels
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        if (line_st.ph == PH_IDLE && bus_tick.cmd_valid) cmd_count[bus_tick.op]++;
        if (line_st.ph == PH_AK_HI && bus_tick.sda_sample &&
            line_st.polls + 9'd1 >= ((line_st.cfg.ack_poll_limit == 8'd0) ? 9'd1 :
                                     {1'b0, line_st.cfg.ack_poll_limit}))
          ack_timeouts++;
        level_q.push_back(step_bus(line_st, bus_tick));
        ticks_taken++;
      end
      if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
        bus_tick = tick_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, bus_tick.sda_sample, bus_tick.reply_nack, bus_tick.send_data};
        s_tuser  <= {bus_tick.op, bus_tick.cmd_valid};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 250) begin
      hold_done <= 1'b1;
      hold_left <= 200;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      results_seen <= results_seen + 1;
      if (level_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h", $time, m_tdata);
        errors++;
      end else begin
        want = level_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
        check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("received_data", want.received_data, got.received_data);
        check_field("nack_seen", 8'(want.nack_seen), 8'(got.nack_seen));
        check_field("pad", 8'(want.pad), 8'(got.pad));
      end
    end
  end

  initial begin
    #30000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [15:0] hp;
    logic [7:0]  lim;
    int          ack_after;
    int          n;
    int          chunk_start;
    plan_st = '0;
    plan_st.cfg.half_period_ticks = HALF_PERIOD_RESET;
    plan_st.cfg.ack_poll_limit    = ACK_POLL_RESET;
    plan_st.ph  = PH_IDLE;
    plan_st.scl = 1'b1;
    plan_st.sda = 1'b1;
    line_st = plan_st;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: start, late ACK, read under command noise, stop
    idle_ticks(3);
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 0, 100);
    run_command(OP_WRITE, 8'hA5, 1'b0, 8'h00, 3, 20);
    run_command(OP_READ, 8'h3C, 1'b0, 8'h96, 0, 100);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 100);
    idle_ticks(4);
    drain();

    // zero half period and zero poll limit behave as one
    set_bus(16'd0, 8'd0);
    run_command(OP_START, 8'h81, 1'b1, 8'h00, 0, 50);
    run_command(OP_WRITE, 8'h81, 1'b0, 8'h00, 1000, 50);
    run_command(OP_READ, 8'h7E, 1'b1, 8'h69, 0, 50);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 50);
    drain();

    set_bus(16'd1, 8'd255);
    run_command(OP_WRITE, 8'hC3, 1'b0, 8'h00, 2, 20);
    run_command(OP_READ, 8'h00, 1'b0, 8'h3C, 0, 20);
    run_command(OP_START, 8'h00, 1'b0, 8'h00, 0, 20);
    run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 0, 20);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(9))
        0:       hp = 16'd0;
        7, 8:    hp = 16'($urandom_range(12, 5));
        9:       hp = 16'd1;
        default: hp = 16'($urandom_range(4, 1));
      endcase
      case ($urandom_range(9))
        0:       lim = 8'd0;
        1:       lim = 8'd255;
        default: lim = 8'($urandom_range(6, 1));
      endcase
      set_bus(hp, lim);
      chunk_start = queued;
      while (queued - chunk_start < 150) begin
        ack_after = ($urandom_range(9) == 0) ? 1000 : $urandom_range(3);
        run_command(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 8'($urandom_range(255)), ack_after,
                    $urandom_range(1) ? 20 : 0);
        if ($urandom_range(3) == 0) idle_ticks($urandom_range(3));
      end
      drain();
    end

    while (tick_q.size() != 0 || s_tvalid) @(posedge clk);
    n = 0;
    while (level_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (level_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, level_q.size());
      errors++;
    end
    $display("Ran %0d bus ticks over %0d register settings, %0d ACK timeouts", ticks_taken,
             settings, ack_timeouts);
    $display("Commands taken: %0d start, %0d stop, %0d write, %0d read", cmd_count[OP_START],
             cmd_count[OP_STOP], cmd_count[OP_WRITE], cmd_count[OP_READ]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
